### rtl/satc_pkg.sv
// shared types and constants of the set-associative cache tag controller
// cache geometry, operation codes and the per-set row layout; no dependencies

package satc_pkg;

  localparam int unsigned SETS      = 64;  // power of two
  localparam int unsigned WAYS      = 4;   // power of two
  localparam int unsigned ADDR_BITS = 32;

  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned IDX_MAX = $clog2(SETS);
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned LFSR_W = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_INVAL = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_OFFSET_BITS    = 3'd0,
    REG_INDEX_BITS     = 3'd1,
    REG_WRITE_BACK     = 3'd2,
    REG_RANDOM_REPLACE = 3'd3,
    REG_HIT_COST       = 3'd4,
    REG_MEMORY_COST    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [WAY_W-1:0] rank;
    logic [TAG_W-1:0] tag;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  // outcome of one lookup, from the set update logic to the top level
  typedef struct packed {
    logic hit;
    logic eviction;
    logic dirty_eviction;
    logic invalidated;
  } upd_flags_t;

  // contents of a set that was never written
  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < WAYS; w++) begin
      r[w].valid = 1'b0;
      r[w].dirty = 1'b0;
      r[w].rank  = WAY_W'(w);
      r[w].tag   = '0;
    end
    return r;
  endfunction

endpackage

### rtl/satc_set_update.sv
// next contents of one cache set for a read, write or snooped invalidation
// compares all ways at once, picks the victim and reorders recency ranks; uses satc_pkg

module satc_set_update import satc_pkg::*; (
  input  row_t              row_i,
  input  logic [1:0]        op_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic              write_back_i,
  input  logic              random_replace_i,
  input  logic [LFSR_W-1:0] lfsr_i,
  output row_t              row_o,
  output logic [LFSR_W-1:0] lfsr_o,
  output upd_flags_t        flags_o
);

  function automatic row_t promote(row_t r, logic [WAY_W-1:0] w);
    row_t             n;
    logic [WAY_W-1:0] rk;
    n  = r;
    rk = r[w].rank;
    for (int i = 0; i < WAYS; i++) begin
      if (r[i].rank < rk) n[i].rank = r[i].rank + WAY_W'(1);
    end
    n[w].rank = '0;
    return n;
  endfunction

  function automatic row_t demote(row_t r, logic [WAY_W-1:0] w);
    row_t             n;
    logic [WAY_W-1:0] rk;
    n  = r;
    rk = r[w].rank;
    for (int i = 0; i < WAYS; i++) begin
      if (r[i].rank > rk) n[i].rank = r[i].rank - WAY_W'(1);
    end
    n[w].rank = WAY_W'(WAYS - 1);
    return n;
  endfunction

  logic [WAYS-1:0]   match;
  logic              any_match;
  logic [WAY_W-1:0]  hit_way;
  logic              have_free;
  logic [WAY_W-1:0]  free_way;
  logic [WAY_W-1:0]  free_rank;
  logic [LFSR_W-1:0] lfsr_step;
  logic [WAY_W-1:0]  want_rank;
  logic [WAY_W-1:0]  victim_way;
  logic [WAY_W-1:0]  fill_way;
  logic              is_write;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_i[w].valid && (row_i[w].tag == tag_i);
    end
  end

  assign any_match = |match;
  assign is_write  = (op_i == OP_WRITE);

  // first matching way
  always_comb begin
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
    end
  end

  // invalid way of lowest rank
  always_comb begin
    have_free = 1'b0;
    free_way  = '0;
    free_rank = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!row_i[w].valid && (!have_free || row_i[w].rank < free_rank)) begin
        have_free = 1'b1;
        free_way  = WAY_W'(w);
        free_rank = row_i[w].rank;
      end
    end
  end

  assign lfsr_step = lfsr_i[0] ? ((lfsr_i >> 1) ^ LFSR_TAPS) : (lfsr_i >> 1);
  assign want_rank = random_replace_i ? lfsr_step[WAY_W-1:0] : WAY_W'(WAYS - 1);

  always_comb begin
    victim_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row_i[w].rank == want_rank) victim_way = WAY_W'(w);
    end
  end

  assign fill_way = have_free ? free_way : victim_way;

  always_comb begin
    row_o   = row_i;
    lfsr_o  = lfsr_i;
    flags_o = '0;
    unique case (op_i)
      OP_INVAL: begin
        for (int w = 0; w < WAYS; w++) begin
          if (match[w]) begin
            row_o          = demote(row_o, WAY_W'(w));
            row_o[w].valid = 1'b0;
            row_o[w].dirty = 1'b0;
          end
        end
        flags_o.invalidated = any_match;
      end
      OP_READ, OP_WRITE: begin
        if (any_match) begin
          flags_o.hit = 1'b1;
          if (is_write && write_back_i) row_o[hit_way].dirty = 1'b1;
          row_o = promote(row_o, hit_way);
        end else begin
          if (!have_free) begin
            flags_o.eviction       = 1'b1;
            flags_o.dirty_eviction = row_i[victim_way].dirty;
            if (random_replace_i) lfsr_o = lfsr_step;
          end
          row_o[fill_way].tag   = tag_i;
          row_o[fill_way].valid = 1'b1;
          row_o[fill_way].dirty = is_write && write_back_i;
          row_o = promote(row_o, fill_way);
        end
      end
      default: begin
        row_o = row_i;
      end
    endcase
  end

endmodule

### rtl/set_assoc_cache_tag_controller.sv
// top level of the set-associative cache tag controller
// set memory, lookup pipeline, cost and running totals; uses satc_pkg and satc_set_update
//
// usage:
//   s_axis carries one access per transfer: a read, a write or a snooped
//   invalidation with its byte address. m_axis returns one result per access:
//   hit, eviction, dirty eviction, cycles charged, invalidate broadcast,
//   snoop outcome and the running hit, miss, eviction and cycle totals.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the geometry, policy and cost
//   registers; write them only while no access is in flight.
// timing:
//   the set row is read from memory at the input transfer, updated in the
//   lookup stage and written back as the result register loads. one access
//   per cycle is sustained while m_axis_tready is high; back-to-back accesses
//   to the same set take the freshly written row through a bypass.
// reset:
//   all sets read as empty with ranks in way order, the replacement LFSR is
//   seeded and totals are cleared; no clearing sweep is needed.
// stall:
//   when m_axis_tready is low the result register holds and the pipeline
//   fills; s_axis_tready drops while both stages are occupied and the
//   result is not taken.

module set_assoc_cache_tag_controller import satc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] operation, [33:2] byte_address, [39:34] zero
  input  logic [39:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] hit, [1] eviction, [2] dirty_eviction, [14:3] access_cycles,
  // [15] send_invalidate, [16] invalidated, [48:17] hit_count,
  // [80:49] miss_count, [112:81] evict_count, [160:113] cycle_total, [167:161] zero
  output logic [167:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [9:0]   cfg_data_i
);

  localparam int unsigned CYC_W = 12;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned SUM_W = 48;

  // configuration
  logic [3:0] offset_bits_q;
  logic [2:0] index_bits_q;
  logic       write_back_q;
  logic       random_q;
  logic [7:0] hit_cost_q;
  logic [9:0] mem_cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= 4'd6;
      index_bits_q  <= 3'd6;
      write_back_q  <= 1'b1;
      random_q      <= 1'b0;
      hit_cost_q    <= 8'd1;
      mem_cost_q    <= 10'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_OFFSET_BITS:    offset_bits_q <= cfg_data_i[3:0];
        REG_INDEX_BITS:     index_bits_q  <= cfg_data_i[2:0];
        REG_WRITE_BACK:     write_back_q  <= cfg_data_i[0];
        REG_RANDOM_REPLACE: random_q      <= cfg_data_i[0];
        REG_HIT_COST:       hit_cost_q    <= cfg_data_i[7:0];
        REG_MEMORY_COST:    mem_cost_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // address split of the incoming access
  logic [1:0]           in_op;
  logic [ADDR_BITS-1:0] in_addr;
  logic [ADDR_BITS-1:0] in_block;
  logic [2:0]           idx_eff;
  logic [SET_W-1:0]     set_mask;
  logic [SET_W-1:0]     in_set;
  logic [TAG_W-1:0]     in_tag;

  assign in_op    = s_axis_tdata[1:0];
  assign in_addr  = s_axis_tdata[33:2];
  assign in_block = in_addr >> offset_bits_q;
  assign idx_eff  = (int'(index_bits_q) > int'(IDX_MAX)) ? 3'(IDX_MAX) : index_bits_q;
  assign set_mask = SET_W'((33'(1) << idx_eff) - 33'(1));
  assign in_set   = in_block[SET_W-1:0] & set_mask;
  assign in_tag   = TAG_W'(in_block >> idx_eff);

  // pipeline handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic s_fire;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  // lookup stage registers
  logic [1:0]       s1_op_q;
  logic [SET_W-1:0] s1_set_q;
  logic [TAG_W-1:0] s1_tag_q;
  row_t             mem_rd_q;
  logic             row_vld_rd_q;
  logic             fwd_q;
  row_t             fwd_row_q;
  row_t             s1_row;

  // set memory and per-set written marks
  row_t             set_mem_q [SETS];
  logic [SETS-1:0]  row_vld_q;
  row_t             row_new;
  logic             bypass;

  assign bypass = s1_adv && (s1_set_q == in_set);

  always_ff @(posedge clk_i) begin
    if (s1_adv) set_mem_q[s1_set_q] <= row_new;
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mem_rd_q     <= set_mem_q[in_set];
      row_vld_rd_q <= row_vld_q[in_set];
      fwd_row_q    <= row_new;
      s1_op_q      <= in_op;
      s1_set_q     <= in_set;
      s1_tag_q     <= in_tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q  <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (s1_adv) row_vld_q[s1_set_q] <= 1'b1;
      if (s_fire) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= bypass;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  assign s1_row = fwd_q ? fwd_row_q : (row_vld_rd_q ? mem_rd_q : reset_row());

  // set update
  logic [LFSR_W-1:0] lfsr_q;
  logic [LFSR_W-1:0] lfsr_d;
  upd_flags_t        flags;

  satc_set_update u_set_update (
    .row_i            (s1_row),
    .op_i             (s1_op_q),
    .tag_i            (s1_tag_q),
    .write_back_i     (write_back_q),
    .random_replace_i (random_q),
    .lfsr_i           (lfsr_q),
    .row_o            (row_new),
    .lfsr_o           (lfsr_d),
    .flags_o          (flags)
  );

  // cost and totals
  logic             is_access;
  logic             is_write;
  logic [CYC_W-1:0] mem_part;
  logic [CYC_W-1:0] cycles;
  logic [CNT_W-1:0] hits_q, hits_d;
  logic [CNT_W-1:0] misses_q, misses_d;
  logic [CNT_W-1:0] evicts_q, evicts_d;
  logic [SUM_W-1:0] cyc_sum_q, cyc_sum_d;
  logic [SUM_W:0]   cyc_sum_ext;

  assign is_write  = (s1_op_q == OP_WRITE);
  assign is_access = (s1_op_q == OP_READ) || is_write;

  assign mem_part = ((is_write && !write_back_q) ? CYC_W'(mem_cost_q) : '0)
                  + ((!is_write && !flags.hit) ? CYC_W'(mem_cost_q) : '0)
                  + (flags.dirty_eviction ? CYC_W'(mem_cost_q) : '0);
  assign cycles   = is_access ? (CYC_W'(hit_cost_q) + mem_part) : '0;

  assign cyc_sum_ext = {1'b0, cyc_sum_q} + (SUM_W + 1)'(cycles);
  assign cyc_sum_d   = cyc_sum_ext[SUM_W] ? '1 : cyc_sum_ext[SUM_W-1:0];

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (is_access) begin
      if (flags.hit) begin
        if (hits_q != '1) hits_d = hits_q + CNT_W'(1);
      end else begin
        if (misses_q != '1) misses_d = misses_q + CNT_W'(1);
      end
      if (flags.eviction && evicts_q != '1) evicts_d = evicts_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q    <= LFSR_SEED;
      hits_q    <= '0;
      misses_q  <= '0;
      evicts_q  <= '0;
      cyc_sum_q <= '0;
    end else if (s1_adv) begin
      lfsr_q    <= lfsr_d;
      hits_q    <= hits_d;
      misses_q  <= misses_d;
      evicts_q  <= evicts_d;
      cyc_sum_q <= cyc_sum_d;
    end
  end

  // result register
  logic [167:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= {7'd0, cyc_sum_d, evicts_d, misses_d, hits_d,
                     flags.invalidated, is_write, cycles,
                     flags.dirty_eviction, flags.eviction, flags.hit};
    end
  end

  assign m_axis_tdata = out_data_q;

endmodule

### verif/satc_result_checker.sv
// result checker of the set-associative cache tag controller testbench
// mirrors tags, valid/dirty bits, ranks, lfsr and totals; uses satc_pkg
// also holds satc_check_pkg, the unused operation code for the testbench top

package satc_check_pkg;

  // code with no operation behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;

endpackage

module satc_result_checker import satc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // [1:0] operation, [33:2] byte_address, [39:34] zero
  input  logic [39:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] hit, [1] eviction, [2] dirty_eviction, [14:3] access_cycles,
  // [15] send_invalidate, [16] invalidated, [48:17] hit_count,
  // [80:49] miss_count, [112:81] evict_count, [160:113] cycle_total
  input  logic [167:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [9:0]   cfg_data_i,
  output int           error_count_o,
  output int           pending_o
);

  localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned CYCLE_MAX = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        hit;
    logic        eviction;
    logic        dirty_eviction;
    logic [11:0] access_cycles;
    logic        send_invalidate;
    logic        invalidated;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] evict_count;
    logic [47:0] cycle_total;
  } access_result_t;

  logic [31:0]      tag_mem   [SETS][WAYS];
  logic             valid_mem [SETS][WAYS];
  logic             dirty_mem [SETS][WAYS];
  logic [WAY_W-1:0] rank_mem  [SETS][WAYS];
  logic [15:0]      victim_lfsr;
  longint unsigned  hits_total, misses_total, evictions_total, cycles_sum;

  logic [3:0] offset_bits_q;
  logic [2:0] index_bits_q;
  logic       write_back_q;
  logic       random_replace_q;
  logic [7:0] hit_cost_q;
  logic [9:0] memory_cost_q;

  access_result_t expected_results[$];
  int             mismatch_count = 0;

  assign error_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [47:0] got, input logic [47:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
  endtask

  function automatic access_result_t unpack_result(input logic [167:0] d);
    access_result_t r;
    r.hit             = d[0];
    r.eviction        = d[1];
    r.dirty_eviction  = d[2];
    r.access_cycles   = d[14:3];
    r.send_invalidate = d[15];
    r.invalidated     = d[16];
    r.hit_count       = d[48:17];
    r.miss_count      = d[80:49];
    r.evict_count     = d[112:81];
    r.cycle_total     = d[160:113];
    return r;
  endfunction

  task automatic clear_model();
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        tag_mem[s][w]   = '0;
        valid_mem[s][w] = 1'b0;
        dirty_mem[s][w] = 1'b0;
        rank_mem[s][w]  = WAY_W'(w);
      end
    victim_lfsr      = LFSR_SEED;
    hits_total       = 0;
    misses_total     = 0;
    evictions_total  = 0;
    cycles_sum       = 0;
    offset_bits_q    = 4'd6;
    index_bits_q     = 3'd6;
    write_back_q     = 1'b1;
    random_replace_q = 1'b0;
    hit_cost_q       = 8'd1;
    memory_cost_q    = 10'd100;
    expected_results.delete();
  endtask

  // most recently used goes to rank 0, the ones ahead of it move back by one
  task automatic promote_way(input int s, input int w);
    logic [WAY_W-1:0] r;
    r = rank_mem[s][w];
    for (int i = 0; i < WAYS; i++)
      if (rank_mem[s][i] < r) rank_mem[s][i]++;
    rank_mem[s][w] = '0;
  endtask

  task automatic demote_way(input int s, input int w);
    logic [WAY_W-1:0] r;
    r = rank_mem[s][w];
    for (int i = 0; i < WAYS; i++)
      if (rank_mem[s][i] > r) rank_mem[s][i]--;
    rank_mem[s][w] = WAY_W'(WAYS - 1);
  endtask

  task automatic lookup_access(input logic [1:0] op, input logic [31:0] addr,
                               output access_result_t res);
    int          k, set_nr, found, victim, victim_rank, want;
    logic [31:0] block, tag;
    logic        hit, evict, dirty_ev, inval, is_write;
    int          cycles;
    k        = index_bits_q;
    hit      = 1'b0;
    evict    = 1'b0;
    dirty_ev = 1'b0;
    inval    = 1'b0;
    is_write = (op == OP_WRITE);
    cycles   = 0;
    while (k > 0 && (1 << k) > SETS) k--;
    block  = addr >> offset_bits_q;
    set_nr = int'(block & 32'((1 << k) - 1));
    tag    = block >> k;

    if (op == OP_INVAL) begin
      for (int w = 0; w < WAYS; w++)
        if (valid_mem[set_nr][w] && tag_mem[set_nr][w] == tag) begin
          valid_mem[set_nr][w] = 1'b0;
          dirty_mem[set_nr][w] = 1'b0;
          demote_way(set_nr, w);
          inval = 1'b1;
        end
    end else if (op == OP_READ || op == OP_WRITE) begin
      found = WAYS;
      for (int w = WAYS - 1; w >= 0; w--)
        if (valid_mem[set_nr][w] && tag_mem[set_nr][w] == tag) found = w;
      if (found < WAYS) begin
        hit = 1'b1;
        if (is_write && write_back_q) dirty_mem[set_nr][found] = 1'b1;
        promote_way(set_nr, found);
      end else begin
        victim      = WAYS;
        victim_rank = WAYS;
        for (int w = 0; w < WAYS; w++)
          if (!valid_mem[set_nr][w] && rank_mem[set_nr][w] < victim_rank) begin
            victim      = w;
            victim_rank = rank_mem[set_nr][w];
          end
        if (victim == WAYS) begin
          // full set: lru way, or the way at the rank the lfsr picks
          evict = 1'b1;
          want  = WAYS - 1;
          if (random_replace_q) begin
            if (victim_lfsr[0]) victim_lfsr = (victim_lfsr >> 1) ^ LFSR_TAPS;
            else victim_lfsr = victim_lfsr >> 1;
            want = int'(victim_lfsr % WAYS);
          end
          victim = 0;
          for (int w = 0; w < WAYS; w++)
            if (rank_mem[set_nr][w] == want) victim = w;
          dirty_ev = dirty_mem[set_nr][victim];
        end
        tag_mem[set_nr][victim]   = tag;
        valid_mem[set_nr][victim] = 1'b1;
        dirty_mem[set_nr][victim] = is_write && write_back_q;
        promote_way(set_nr, victim);
      end
      cycles = hit_cost_q;
      if (is_write && !write_back_q) cycles += memory_cost_q;
      if (!is_write && !hit) cycles += memory_cost_q;
      if (dirty_ev) cycles += memory_cost_q;
      if (CYCLE_MAX - cycles_sum < longint'(cycles)) cycles_sum = CYCLE_MAX;
      else cycles_sum += cycles;
      if (hit) begin
        if (hits_total < COUNT_MAX) hits_total++;
      end else begin
        if (misses_total < COUNT_MAX) misses_total++;
      end
      if (evict && evictions_total < COUNT_MAX) evictions_total++;
    end

    res.hit             = hit;
    res.eviction        = evict;
    res.dirty_eviction  = dirty_ev;
    res.access_cycles   = cycles[11:0];
    res.send_invalidate = is_write;
    res.invalidated     = inval;
    res.hit_count       = hits_total[31:0];
    res.miss_count      = misses_total[31:0];
    res.evict_count     = evictions_total[31:0];
    res.cycle_total     = cycles_sum[47:0];
  endtask

  always @(posedge clk_i) begin : watch
    access_result_t got, want, fresh;
    if (!rst_ni) begin
      clear_model();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_OFFSET_BITS:    offset_bits_q    = cfg_data_i[3:0];
          REG_INDEX_BITS:     index_bits_q     = cfg_data_i[2:0];
          REG_WRITE_BACK:     write_back_q     = cfg_data_i[0];
          REG_RANDOM_REPLACE: random_replace_q = cfg_data_i[0];
          REG_HIT_COST:       hit_cost_q       = cfg_data_i[7:0];
          REG_MEMORY_COST:    memory_cost_q    = cfg_data_i[9:0];
          default: ;
        endcase
      end
      // the result leaving now is older than any access entering now
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_result(m_axis_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no access outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("hit", got.hit, want.hit);
          check_field("eviction", got.eviction, want.eviction);
          check_field("dirty_eviction", got.dirty_eviction, want.dirty_eviction);
          check_field("access_cycles", got.access_cycles, want.access_cycles);
          check_field("send_invalidate", got.send_invalidate, want.send_invalidate);
          check_field("invalidated", got.invalidated, want.invalidated);
          check_field("hit_count", got.hit_count, want.hit_count);
          check_field("miss_count", got.miss_count, want.miss_count);
          check_field("evict_count", got.evict_count, want.evict_count);
          check_field("cycle_total", got.cycle_total, want.cycle_total);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lookup_access(s_axis_tdata[1:0], s_axis_tdata[33:2], fresh);
        expected_results = {expected_results, fresh};
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

### verif/set_assoc_cache_tag_controller_test.sv
// testbench top of the set-associative cache tag controller
// drives accesses, register writes and back-pressure; satc_result_checker does the checking

module set_assoc_cache_tag_controller_test
  import satc_pkg::*;
  import satc_check_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ROUND_ITEMS  = 150;
  localparam int NUM_ROUNDS   = 6;
  localparam int LONG_HOLD    = 300;
  localparam int NUM_DIRECTED = 18;

  // {byte_address, operation}; reset geometry puts the tag at bit 12
  localparam logic [33:0] DIRECTED [NUM_DIRECTED] = '{
    {32'h0000_0000, OP_READ},   // cold miss
    {32'h0000_0000, OP_READ},   // hit
    {32'h0000_003F, OP_WRITE},  // write hit, block turns dirty
    {32'hFFFF_FFFF, OP_READ},
    {32'hFFFF_FFFF, OP_WRITE},
    {32'hFFFF_FFFF, OP_INVAL},  // clears a block
    {32'hFFFF_FFFF, OP_INVAL},  // nothing left to clear
    {32'h1234_5678, OP_UNUSED},
    {32'h0000_1000, OP_WRITE},
    {32'h0000_2000, OP_READ},
    {32'h0000_3000, OP_READ},   // set 0 now full
    {32'h0000_4000, OP_READ},   // evicts the dirty lru block
    {32'h0000_0000, OP_READ},   // evicts another dirty one
    {32'h0000_2000, OP_INVAL},
    {32'h0000_5000, OP_READ},   // refills the freed way
    {32'h8000_0000, OP_WRITE},
    {32'h7FFF_FFFF, OP_READ},
    {32'h0000_5000, OP_WRITE}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [9:0]   cfg_data_i = '0;

  int error_count, pending;
  int sender_idle_pct = 15;
  int receiver_idle_pct = 57;
  logic hold_request = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int cur_offset = 6;
  int cur_index = 6;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  set_assoc_cache_tag_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  satc_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      m_axis_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // valid stays high from one transfer to the next unless a gap is drawn
  task automatic send_access(input logic [1:0] op, input logic [31:0] addr);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, addr, op};
    do @(posedge clk_i); while (!s_axis_tready);
    op_count[op]++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [9:0] off, input logic [9:0] idx,
                                input logic [9:0] wb, input logic [9:0] rnd,
                                input logic [9:0] hc, input logic [9:0] mc);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_OFFSET_BITS;    cfg_data_i <= off; @(posedge clk_i);
    cfg_idx_i <= REG_INDEX_BITS;     cfg_data_i <= idx; @(posedge clk_i);
    cfg_idx_i <= REG_WRITE_BACK;     cfg_data_i <= wb;  @(posedge clk_i);
    cfg_idx_i <= REG_RANDOM_REPLACE; cfg_data_i <= rnd; @(posedge clk_i);
    cfg_idx_i <= REG_HIT_COST;       cfg_data_i <= hc;  @(posedge clk_i);
    cfg_idx_i <= REG_MEMORY_COST;    cfg_data_i <= mc;  @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_offset = int'(off);
    cur_index  = (int'(idx) > int'(IDX_MAX)) ? int'(IDX_MAX) : int'(idx);
  endtask

  // mostly a few tags over a few sets so hits, fills and evictions all occur
  task automatic random_access();
    logic [1:0]  op;
    logic [31:0] addr, tag, set_nr;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 45) op = OP_READ;
    else if (pick < 85) op = OP_WRITE;
    else if (pick < 97) op = OP_INVAL;
    else op = OP_UNUSED;
    if ($urandom_range(99) < 10) begin
      addr = $urandom;
    end else begin
      tag    = $urandom_range(0, 9);
      set_nr = $urandom_range(0, 3) & ((32'd1 << cur_index) - 1);
      addr   = (tag << (cur_offset + cur_index)) | (set_nr << cur_offset)
             | ($urandom & ((32'd1 << cur_offset) - 1));
    end
    send_access(op, addr);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_access(DIRECTED[i][1:0], DIRECTED[i][33:2]);
    drain();

    for (int round = 0; round < NUM_ROUNDS; round++) begin
      if (round < 2) begin
        sender_idle_pct   <= 15;
        receiver_idle_pct <= 57;
      end else if (round < 4) begin
        sender_idle_pct   <= 57;
        receiver_idle_pct <= 15;
      end else begin
        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
      end
      case (round)
        0: apply_settings(10'd0, 10'd0, 10'd1, 10'd0, 10'd0, 10'd0);
        1: apply_settings(10'd15, 10'd7, 10'd0, 10'd1, 10'd255, 10'd1023);
        2: apply_settings(10'd4, 10'd2, 10'd1, 10'd1, 10'($urandom_range(0, 255)),
                          10'($urandom_range(0, 1023)));
        3: apply_settings(10'd6, 10'd3, 10'd0, 10'd0, 10'($urandom_range(0, 255)),
                          10'($urandom_range(0, 1023)));
        4: apply_settings(10'd12, 10'd6, 10'd1, 10'd0, 10'($urandom_range(0, 255)),
                          10'($urandom_range(0, 1023)));
        default: apply_settings(10'($urandom_range(0, 15)), 10'($urandom_range(0, 7)),
                                10'($urandom_range(0, 1)), 10'd1,
                                10'($urandom_range(0, 255)),
                                10'($urandom_range(0, 1023)));
      endcase
      // back-to-back input while the output is held off fills the pipeline
      if (round == 4) hold_request <= 1'b1;
      repeat (ROUND_ITEMS) random_access();
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d accesses: %0d reads, %0d writes, %0d snoops, %0d unused codes",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("over seven register settings with stalls on both sides and one long hold-off");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/satc_pkg.sv
rtl/satc_set_update.sv
rtl/set_assoc_cache_tag_controller.sv
verif/satc_result_checker.sv
verif/set_assoc_cache_tag_controller_test.sv
